// File: design/wli_pkg.sv
// ----------------------------------------------------------------------------
// wli_pkg: shared types and constants for the waypoint interpolator
// Holds command and status codes and the default sizes.
// ----------------------------------------------------------------------------
package wli_pkg;

	localparam int DefMaxPoints = 64;
	localparam int DefFracBits  = 16;
	localparam int NComp        = 9;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RSVD  = 2'd3
	} status_t;

endpackage

// File: design/wli_ram.sv
// ----------------------------------------------------------------------------
// wli_ram: generic single-port RAM
// One read per cycle with an optional write to the same address; read data is registered (old word on a write).
// ----------------------------------------------------------------------------
module wli_ram #(
	parameter int Width = 32,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// File: design/wli_div.sv
// ----------------------------------------------------------------------------
// wli_div: restoring unsigned divider, one quotient bit a cycle
// Computes (num << FracBits) / den for num <= den, quotient of FracBits+1 bits.
// ----------------------------------------------------------------------------
module wli_div
	import wli_pkg::*;
#(
	parameter int FracBits = DefFracBits
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [32:0]           num,
	input  logic [32:0]           den,
	output logic                  done,
	output logic [FracBits:0]     quo
);

	localparam int CntW = $clog2(FracBits + 1);

	logic [33:0]     rem_q;
	logic [32:0]     den_q;
	logic [FracBits:0] quo_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic [33:0]     trial;

	assign trial = {rem_q[32:0], 1'b0} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(FracBits);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// The integer bit of the quotient is settled by one compare at start; the
	// remaining FracBits bits follow one a cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= (num >= den) ? {1'b0, num - den} : {1'b0, num};
			den_q <= den;
			quo_q <= (FracBits+1)'(num >= den);
		end else if (busy_q) begin
			if (!trial[33]) begin
				rem_q <= trial;
				quo_q <= {quo_q[FracBits-1:0], 1'b1};
			end else begin
				rem_q <= {rem_q[32:0], 1'b0};
				quo_q <= {quo_q[FracBits-1:0], 1'b0};
			end
		end
	end

	assign quo = quo_q;

endmodule

// File: design/waypoint_linear_interpolator_top.sv
// ----------------------------------------------------------------------------
// waypoint_linear_interpolator_top: sorted waypoint table with interpolation
// Loads waypoints by insertion sort, answers clamped linear queries.
// ----------------------------------------------------------------------------
//  Channel   Dir  Signals                                   Contents
//  s_axis    in   tvalid tready tuser[1:0] tdata[319:0]    cmd; time, nine components
//  m_axis    out  tvalid tready tuser[1:0] tdata[351:0]    status; components, times
//
// One beat is in flight at a time; s_tready is high only in the idle state.
// A clear, no-op, dropped load or empty query goes straight to fetching the
// first and last times, as every item does before m_tvalid. A load moves
// each later entry up one slot, component by component, then writes the new
// point; a query scans the times from the front, divides for the fraction
// when the time lies inside a segment, and interpolates each component.
// Reset clears only the point count and the control; table contents are
// undefined until loaded. A stalled result holds the block until m_tready.
// ----------------------------------------------------------------------------
module waypoint_linear_interpolator_top
	import wli_pkg::*;
#(
	parameter int MAX_POINTS = DefMaxPoints,
	parameter int FRAC_BITS  = DefFracBits
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// cmd[1:0]
	input  logic [1:0]   s_tuser,
	// item_time[31:0], then pos_x..att_z in 32 bit slices from bit 32
	input  logic [319:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// status[1:0]
	output logic [1:0]   m_tuser,
	// pos_x..att_z in 32 bit slices from bit 0, start_time, end_time
	output logic [351:0] m_tdata
);

	localparam int AW   = $clog2(MAX_POINTS);
	localparam int CW   = $clog2(MAX_POINTS + 1);
	localparam int CD   = MAX_POINTS * NComp;
	localparam int CAW  = $clog2(CD);

	typedef enum logic [3:0] {
		S_IDLE, S_LRD, S_LWAIT, S_LMOVE, S_LWR, S_QRD, S_QWALK,
		S_QDIV, S_QRA, S_QRB, S_QMUL, S_QADD, S_TRD, S_TWAIT, S_OUT
	} state_t;

	state_t state_q;

	// Input item latch.
	logic [31:0]  t_q;
	logic [31:0]  in_q [NComp];
	// Table bookkeeping.
	logic [CW-1:0] count_q;
	logic [CW-1:0] pos_q;     // load slot or query walk index
	logic [3:0]    comp_q;
	logic          moving_q;
	logic [AW-1:0] seg_q;
	logic [31:0]   ta_q;
	logic [31:0]   tb_q;
	logic [31:0]   va_q;
	logic [FRAC_BITS:0] f_q;
	logic signed [64:0] prod_s1;
	logic [31:0]   res_q [NComp];
	logic [1:0]    status_q;
	logic [31:0]   first_q;
	logic [31:0]   last_q;
	logic [1:0]    wait_q;

	// Memories.
	logic          t_we;
	logic [AW-1:0] t_addr;
	logic [31:0]   t_wdata, t_rdata;
	logic          c_we;
	logic [CAW-1:0] c_addr;
	logic [31:0]   c_wdata, c_rdata;

	wli_ram #(.Width(32), .Depth(MAX_POINTS)) u_times (
		.clk(clk), .we(t_we), .addr(t_addr), .wdata(t_wdata), .rdata(t_rdata)
	);
	wli_ram #(.Width(32), .Depth(CD)) u_comps (
		.clk(clk), .we(c_we), .addr(c_addr), .wdata(c_wdata), .rdata(c_rdata)
	);

	// Divider. Both differences are taken on signed times and are positive.
	logic          div_start, div_done;
	logic [FRAC_BITS:0] div_quo;
	wli_div #(.FracBits(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num({t_q[31], t_q} - {ta_q[31], ta_q}),
		.den({tb_q[31], tb_q} - {ta_q[31], ta_q}),
		.done(div_done), .quo(div_quo)
	);

	function automatic logic [CAW-1:0] caddr(input logic [AW-1:0] p, input logic [3:0] j);
		logic [CAW+3:0] a;
		a = CAW'(p) * (CAW+4)'(NComp) + (CAW+4)'(j);
		return a[CAW-1:0];
	endfunction

	// Memory port drive, decoded from state.
	logic [AW-1:0] pos_m1;
	assign pos_m1 = AW'(pos_q - 1'b1);

	always_comb begin
		t_we    = 1'b0;
		t_addr  = pos_m1;
		t_wdata = t_q;
		c_we    = 1'b0;
		c_addr  = caddr(pos_m1, comp_q);
		c_wdata = moving_q ? c_rdata : in_q[comp_q];
		unique case (state_q)
			S_LRD, S_LWAIT: begin
				t_addr = pos_m1;
				c_addr = caddr(pos_m1, comp_q);
			end
			S_LMOVE: begin
				t_addr = pos_q[AW-1:0];
				t_we   = (comp_q == 4'd0);
				t_wdata = t_rdata;
				c_addr = caddr(pos_q[AW-1:0], comp_q);
				c_we   = 1'b1;
			end
			S_LWR: begin
				t_addr = pos_q[AW-1:0];
				t_we   = (comp_q == 4'd0);
				c_addr = caddr(pos_q[AW-1:0], comp_q);
				c_we   = 1'b1;
			end
			S_QRD, S_QWALK: t_addr = pos_q[AW-1:0];
			S_QRA: c_addr = caddr(seg_q, comp_q);
			S_QRB: c_addr = caddr(AW'(seg_q + 1'b1), comp_q);
			S_TRD, S_TWAIT: t_addr = (wait_q == 2'd0) ? '0 : AW'(count_q - 1'b1);
			default: ;
		endcase
	end

	assign div_start = (state_q == S_QWALK) && (wait_q == 2'd3);
	assign s_tready  = (state_q == S_IDLE);

	// Floor of product over 2^FRAC_BITS; arithmetic shift floors.
	logic signed [64:0] prod_sh;
	assign prod_sh = prod_s1 >>> FRAC_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			m_tvalid <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (s_tvalid) begin
					t_q      <= s_tdata[31:0];
					for (int k = 0; k < NComp; k++) begin
						in_q[k]  <= s_tdata[32+32*k +: 32];
						res_q[k] <= '0;
					end
					status_q <= ST_OK;
					comp_q   <= '0;
					moving_q <= 1'b0;
					wait_q   <= '0;
					pos_q    <= count_q;
					unique case (cmd_t'(s_tuser))
						CMD_CLEAR: begin
							count_q <= '0;
							state_q <= S_TRD;
						end
						CMD_LOAD: begin
							if (count_q == CW'(MAX_POINTS)) begin
								status_q <= ST_FULL;
								state_q  <= S_TRD;
							end else if (count_q == '0) begin
								state_q <= S_LWR;
							end else begin
								state_q <= S_LRD;
							end
						end
						CMD_QUERY: begin
							if (count_q == '0) begin
								status_q <= ST_EMPTY;
								state_q  <= S_TRD;
							end else begin
								pos_q   <= '0;
								state_q <= S_QRD;
							end
						end
						default: state_q <= S_TRD;
					endcase
				end
				// Load: read entry pos-1, decide shift on its time.
				S_LRD: state_q <= S_LWAIT;
				S_LWAIT: begin
					if (comp_q == 4'd0 && !($signed(t_rdata) > $signed(t_q))) begin
						moving_q <= 1'b0;
						state_q  <= S_LWR;
					end else begin
						moving_q <= 1'b1;
						state_q  <= S_LMOVE;
					end
				end
				S_LMOVE: begin
					if (comp_q == 4'(NComp - 1)) begin
						comp_q   <= '0;
						pos_q    <= pos_q - 1'b1;
						moving_q <= 1'b0;
						state_q  <= (pos_q == CW'(1)) ? S_LWR : S_LRD;
					end else begin
						comp_q  <= comp_q + 1'b1;
						state_q <= S_LRD;
					end
				end
				S_LWR: begin
					if (comp_q == 4'(NComp - 1)) begin
						comp_q  <= '0;
						count_q <= count_q + 1'b1;
						state_q <= S_TRD;
					end else begin
						comp_q <= comp_q + 1'b1;
					end
				end
				// Query: sequential scan of times.
				S_QRD: state_q <= S_QWALK;
				S_QWALK: begin
					if (wait_q == 2'd3) begin
						state_q <= S_QDIV;
					end else if (pos_q == '0) begin
						if (count_q == CW'(1) || !($signed(t_q) > $signed(t_rdata))) begin
							seg_q   <= '0;
							f_q     <= '0;
							state_q <= S_QRA;
						end else if (!($signed(t_q) < $signed(last_q))) begin
							// At or past the end time. Every item fetches the end
							// time for its result, so last_q is current here.
							seg_q   <= AW'(count_q - 1'b1);
							f_q     <= '0;
							state_q <= S_QRA;
						end else begin
							ta_q    <= t_rdata;
							seg_q   <= '0;
							pos_q   <= CW'(1);
							state_q <= S_QRD;
						end
					end else if (!($signed(t_rdata) < $signed(t_q))) begin
						tb_q <= t_rdata;
						if (pos_q == count_q - 1'b1 && !($signed(t_q) < $signed(t_rdata))) begin
							seg_q   <= AW'(pos_q);
							f_q     <= '0;
							state_q <= S_QRA;
						end else if ($signed(t_rdata) == $signed(ta_q)) begin
							f_q     <= '0;
							state_q <= S_QRA;
						end else begin
							wait_q <= 2'd3;
						end
					end else if (pos_q == count_q - 1'b1) begin
						seg_q   <= AW'(pos_q);
						f_q     <= '0;
						state_q <= S_QRA;
					end else begin
						ta_q    <= t_rdata;
						seg_q   <= AW'(pos_q);
						pos_q   <= pos_q + 1'b1;
						state_q <= S_QRD;
					end
				end
				S_QDIV: if (div_done) begin
					f_q     <= div_quo;
					wait_q  <= '0;
					state_q <= S_QRA;
				end
				S_QRA: begin
					state_q <= S_QRB;
				end
				S_QRB: begin
					va_q    <= c_rdata;
					state_q <= S_QMUL;
				end
				S_QMUL: begin
					// A zero fraction keeps the earlier point; the word after
					// it may never have been written.
					if (f_q == '0) begin
						prod_s1 <= '0;
					end else begin
						prod_s1 <= 65'($signed({c_rdata[31], c_rdata} - {va_q[31], va_q}))
							* $signed({1'b0, f_q});
					end
					state_q <= S_QADD;
				end
				S_QADD: begin
					res_q[comp_q] <= va_q + prod_sh[31:0];
					if (comp_q == 4'(NComp - 1)) begin
						state_q <= S_TRD;
					end else begin
						comp_q  <= comp_q + 1'b1;
						state_q <= S_QRA;
					end
				end
				// Fetch first and last times for the result.
				S_TRD: state_q <= S_TWAIT;
				S_TWAIT: begin
					if (wait_q == 2'd0) begin
						first_q <= t_rdata;
						wait_q  <= 2'd1;
						state_q <= S_TRD;
					end else begin
						last_q   <= t_rdata;
						wait_q   <= '0;
						m_tvalid <= 1'b1;
						state_q  <= S_OUT;
					end
				end
				S_OUT: if (m_tready) begin
					m_tvalid <= 1'b0;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	logic empty_out;
	assign empty_out = (count_q == '0);

	assign m_tuser = status_q;

	always_comb begin
		m_tdata = '0;
		for (int k = 0; k < NComp; k++) begin
			m_tdata[32*k +: 32] = res_q[k];
		end
		m_tdata[288 +: 32] = empty_out ? '0 : first_q;
		m_tdata[320 +: 32] = empty_out ? '0 : last_q;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_POINTS))
		else $error("point count beyond table size");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (state_q == S_OUT))
		else $error("result shown outside output state");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_QADD) |-> (f_q <= (FRAC_BITS+1)'(1) << FRAC_BITS))
		else $error("fraction above one");
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("accepted a second item while busy");

endmodule
